### rtl/ket_pkg.sv
package ket_pkg;

  // Defaults for the top-level parameters
  localparam int KEY_COUNT_DEF = 256;
  localparam int TIME_BITS_DEF = 32;

  // Range of scanned key codes
  localparam logic [7:0] SCAN_FIRST = 8'd1;
  localparam logic [7:0] SCAN_LAST  = 8'd254;

  // Register reset values
  localparam logic [7:0] STOP_KEY_RST    = 8'd27;
  localparam logic       STOP_ENABLE_RST = 1'b1;

  localparam logic [31:0] HOLD_MAX = 32'hFFFF_FFFF;

  typedef logic [7:0] code_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_STOP_KEY    = 1'b0,
    CFG_STOP_ENABLE = 1'b1
  } cfg_index_t;

  // Event codes
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DOWN = 2'd1,
    EV_HOLD = 2'd2,
    EV_UP   = 2'd3
  } event_t;

  // Per-key tracking entry
  typedef struct packed {
    logic        pressed;
    logic [31:0] presses;
    logic [31:0] holds;
    logic [31:0] press_time;
    logic [31:0] release_time;
  } entry_t;

  // Update decision handed from the update logic to the top level
  typedef struct packed {
    event_t kind;
    logic   write;
    logic   set_stop;
    logic   live;
  } upd_ctl_t;

endpackage

### rtl/ket_ram.sv
module ket_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/ket_store.sv
module ket_store #(
  parameter int KEY_COUNT = ket_pkg::KEY_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  ket_pkg::code_t   rd_code,
  input  logic             wr_en,
  input  ket_pkg::code_t   wr_code,
  input  ket_pkg::entry_t  wr_data,
  output ket_pkg::entry_t  cur
);

  // Only codes below 256 can ever be tracked
  localparam int Depth = (KEY_COUNT < 256) ? KEY_COUNT : 256;
  localparam int AddrW = $clog2(Depth);
  localparam int EntryW = $bits(ket_pkg::entry_t);

  logic [Depth-1:0] vld;
  logic             vld_rd;
  logic [AddrW-1:0] rd_addr_q;
  logic             lw_valid;
  logic [AddrW-1:0] lw_addr;
  ket_pkg::entry_t  lw_data;
  logic [EntryW-1:0] ram_q;

  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;

  assign rd_addr = rd_code[AddrW-1:0];
  assign wr_addr = wr_code[AddrW-1:0];

  ket_ram #(
    .WIDTH (EntryW),
    .DEPTH (Depth)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Track which entries hold written data; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Hold the valid bit and address alongside the registered read
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_rd <= 1'b0;
    end else if (rd_en) begin
      vld_rd <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
  end

  // Keep the most recent write for bypass
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (wr_en) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_addr <= wr_addr;
      lw_data <= wr_data;
    end
  end

  // Forward the latest write over a read that may have missed it
  always_comb begin
    if (lw_valid && (lw_addr == rd_addr_q)) begin
      cur = lw_data;
    end else if (vld_rd) begin
      cur = ket_pkg::entry_t'(ram_q);
    end else begin
      cur = '0;
    end
  end

endmodule

### rtl/ket_update.sv
module ket_update (
  input  logic              tracked,
  input  logic              stopped,
  input  logic              down,
  input  ket_pkg::code_t    code,
  input  logic [31:0]       now,
  input  ket_pkg::code_t    stop_key,
  input  logic              stop_enable,
  input  ket_pkg::entry_t   cur,
  output ket_pkg::entry_t   nxt,
  output ket_pkg::upd_ctl_t ctl
);

  logic was;

  assign was = cur.pressed;

  // Classify the edge and build the new entry
  always_comb begin
    nxt          = cur;
    ctl.kind     = ket_pkg::EV_NONE;
    ctl.write    = 1'b0;
    ctl.set_stop = 1'b0;
    ctl.live     = tracked && !stopped;
    if (ctl.live) begin
      if (down && !was) begin
        nxt.pressed    = 1'b1;
        nxt.presses    = cur.presses + 32'd1;
        nxt.holds      = 32'd1;
        nxt.press_time = now;
        ctl.kind       = ket_pkg::EV_DOWN;
        ctl.write      = 1'b1;
        ctl.set_stop   = stop_enable && (code == stop_key);
      end else if (down && was) begin
        if (cur.holds != ket_pkg::HOLD_MAX) begin
          nxt.holds = cur.holds + 32'd1;
        end
        ctl.kind  = ket_pkg::EV_HOLD;
        ctl.write = 1'b1;
      end else if (!down && was) begin
        nxt.pressed      = 1'b0;
        nxt.holds        = 32'd0;
        nxt.release_time = now;
        ctl.kind         = ket_pkg::EV_UP;
        ctl.write        = 1'b1;
      end
    end
  end

endmodule

### rtl/key_event_edge_tracker_unit.sv
// Channel  Handshake              Payload
// in       in_valid / in_stall    key_code, key_down, shift_down, ctrl_down, alt_down, time_now
// out      out_valid / out_stall  key_code_out, event_kind, shift_out, ctrl_out, alt_out,
//                                 press_total, hold_total, press_stamp, release_stamp, halted
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle unless the output stalls; items pass the input, then the output register.
// The per-key entry is read from the RAM on acceptance and written back as the item
// leaves the update stage; a bypass of the last write covers the same key arriving
// back to back.
// Reset clears the per-key valid bits, the stop flag and the stage valid flags, and loads the config defaults.
// A stalled output holds the result; the input stalls only when the update stage
// also holds an item.
module key_event_edge_tracker_unit #(
  parameter int KEY_COUNT = ket_pkg::KEY_COUNT_DEF,
  parameter int TIME_BITS = ket_pkg::TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            key_code,
  input  logic                  key_down,
  input  logic                  shift_down,
  input  logic                  ctrl_down,
  input  logic                  alt_down,
  input  logic [31:0]           time_now,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            key_code_out,
  output logic [1:0]            event_kind,
  output logic                  shift_out,
  output logic                  ctrl_out,
  output logic                  alt_out,
  output logic [31:0]           press_total,
  output logic [31:0]           hold_total,
  output logic [31:0]           press_stamp,
  output logic [31:0]           release_stamp,
  output logic                  halted,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  ket_pkg::cfg_index_t   cfg_index,
  input  logic [7:0]            cfg_data
);

  localparam logic [31:0] TimeMask = (TIME_BITS >= 32) ? 32'hFFFF_FFFF :
                                     32'((64'd1 << TIME_BITS) - 64'd1);

  ket_pkg::code_t    stop_key;
  logic              stop_enable;
  logic              stopped;

  logic              s1_valid;
  ket_pkg::code_t    s1_code;
  logic              s1_down;
  logic              s1_shift;
  logic              s1_ctrl;
  logic              s1_alt;
  logic [31:0]       s1_now;
  logic              s1_tracked;

  logic              accept;
  logic              s1_move;
  logic              in_tracked;

  ket_pkg::entry_t   cur;
  ket_pkg::entry_t   nxt;
  ket_pkg::upd_ctl_t ctl;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_key    <= ket_pkg::STOP_KEY_RST;
      stop_enable <= ket_pkg::STOP_ENABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ket_pkg::CFG_STOP_KEY:    stop_key    <= cfg_data;
        ket_pkg::CFG_STOP_ENABLE: stop_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake: advance the update stage whenever the output register frees up
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign accept   = in_valid && !in_stall;

  assign in_tracked = (key_code >= ket_pkg::SCAN_FIRST) && (key_code <= ket_pkg::SCAN_LAST) &&
                      (32'(key_code) < 32'(KEY_COUNT));

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_code    <= key_code;
      s1_down    <= key_down;
      s1_shift   <= shift_down;
      s1_ctrl    <= ctrl_down;
      s1_alt     <= alt_down;
      s1_now     <= time_now & TimeMask;
      s1_tracked <= in_tracked;
    end
  end

  ket_store #(
    .KEY_COUNT (KEY_COUNT)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept && in_tracked),
    .rd_code (key_code),
    .wr_en   (s1_move && ctl.write),
    .wr_code (s1_code),
    .wr_data (nxt),
    .cur     (cur)
  );

  ket_update u_update (
    .tracked     (s1_tracked),
    .stopped     (stopped),
    .down        (s1_down),
    .code        (s1_code),
    .now         (s1_now),
    .stop_key    (stop_key),
    .stop_enable (stop_enable),
    .cur         (cur),
    .nxt         (nxt),
    .ctl         (ctl)
  );

  // Stop flag: set by a Down of the stop key while stopping is enabled, cleared only by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      stopped <= 1'b0;
    end else if (s1_move && ctl.set_stop) begin
      stopped <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_move || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      key_code_out  <= s1_code;
      event_kind    <= ctl.kind;
      shift_out     <= s1_shift;
      ctrl_out      <= s1_ctrl;
      alt_out       <= s1_alt;
      press_total   <= ctl.live ? nxt.presses      : 32'd0;
      hold_total    <= ctl.live ? nxt.holds        : 32'd0;
      press_stamp   <= ctl.live ? nxt.press_time   : 32'd0;
      release_stamp <= ctl.live ? nxt.release_time : 32'd0;
      halted        <= stopped || ctl.set_stop;
    end
  end

endmodule
